/* hw/rtl/edge_centroid_feedback_loop_defines.svh */
// ----------------------------------------------------------------------------
// Edge centroid feedback loop: assertion macros
// Checking macros used by the controller; they reduce to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef EDGE_CENTROID_FEEDBACK_LOOP_DEFINES_SVH
`define EDGE_CENTROID_FEEDBACK_LOOP_DEFINES_SVH
`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define ECFL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent in the same cycle
`define ECFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// consequent in the next cycle
`define ECFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ECFL_ASSERT(lbl, cond, msg)
`define ECFL_ASSERT_IMP(lbl, ante, cons, msg)
`define ECFL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/ecfl_pkg.sv */
// ----------------------------------------------------------------------------
// Edge centroid feedback loop: package
// Widths, register indexes and the command/status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ecfl_pkg;

  // frame and sample geometry
  localparam int FRAME_LENGTH    = 16384;
  localparam int SAMPLE_BITS     = 14;
  localparam int SAT_TAP_SPACING = 10;
  localparam int DLY_DEPTH       = 4 * SAT_TAP_SPACING + 1;
  localparam int POS_W           = $clog2(FRAME_LENGTH);

  // accumulator and result widths
  localparam int EDGE_W      = 15;
  localparam int OFFS_W      = 28;
  localparam int FRAC_BITS   = 8;                 // Q.8 centre error
  localparam int QUO_W       = OFFS_W + FRAC_BITS;
  localparam int CERR_FULL_W = QUO_W + 1;
  localparam int CERR_W      = 23;
  localparam int DECAY_W     = 16;
  localparam int GAIN_W      = 32;
  localparam int HIST_W      = 40;
  localparam int HIST_SPLIT  = 16;
  localparam int DRV_SHIFT   = 24;
  localparam int DRIVE_W     = 18;
  localparam int DRIVE_ONE   = 1 << (DRIVE_W - 2);

  // divider sequencing
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_THRESHOLD   = 3'd0,
    REG_SATURATION_LEVEL = 3'd1,
    REG_WINDOW_START     = 3'd2,
    REG_WINDOW_END       = 3'd3,
    REG_MIN_EDGES        = 3'd4,
    REG_CENTER_OFFSET    = 3'd5,
    REG_DECAY            = 3'd6,
    REG_GAIN             = 3'd7
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic hist_mul;
    logic hist_add;
    logic drv_mul;
    logic drv_sum;
    logic drv_add;
    logic load_out;
  } ecfl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic end_hit;
    logic frame_ok;
  } ecfl_sts_t;

endpackage

/* hw/rtl/edge_centroid_feedback_loop.sv */
// ----------------------------------------------------------------------------
// Edge centroid feedback loop
// Takes one ADC sample word per cycle while in_ready is high, counts rising
// edges and their offsets in a window, checks for saturation and emits one
// result word per frame: centre error and updated, clamped feedback drive.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while in_ready is high. At the sample whose
// index equals window_end the input stalls while the frame-end work runs: a
// setup step and the bit-serial restoring divider that forms the mean edge
// offset, then the integrator multiply and add and the drive multiply, sum
// and add when the frame is valid, and a load of the result register, which
// waits if the previous result word has not yet been taken. The result
// register lets a new frame start while a result still waits on out_ready.
module edge_centroid_feedback_loop import ecfl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DRIVE_W-1:0]     out_drive,
  output logic                          out_frame_valid,
  output logic                          out_saturated,
  output logic [EDGE_W-1:0]             out_edge_total,
  output logic signed [CERR_W-1:0]      out_center_error,
  output logic                          out_rail_hit,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  ecfl_cmd_t cmd;
  ecfl_sts_t sts;

  // sequencing and handshakes
  ecfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  ecfl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .in_frame_start   (in_frame_start),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_drive        (out_drive),
    .out_frame_valid  (out_frame_valid),
    .out_saturated    (out_saturated),
    .out_edge_total   (out_edge_total),
    .out_center_error (out_center_error),
    .out_rail_hit     (out_rail_hit)
  );

endmodule

/* hw/rtl/ecfl_ctrl.sv */
// ----------------------------------------------------------------------------
// Edge centroid feedback loop: controller
// Sequences the frame-end divide, integrator and drive update, and owns the
// word handshakes on both channels.
// ----------------------------------------------------------------------------
`include "edge_centroid_feedback_loop_defines.svh"

module ecfl_ctrl import ecfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ecfl_sts_t sts,
  output ecfl_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DIV_INIT = 9'b000000010,
    ST_DIV      = 9'b000000100,
    ST_HIST_MUL = 9'b000001000,
    ST_HIST_ADD = 9'b000010000,
    ST_DRV_MUL  = 9'b000100000,
    ST_DRV_SUM  = 9'b001000000,
    ST_DRV_ADD  = 9'b010000000,
    ST_LOAD     = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // samples flow only while no frame-end work is pending
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.accept    = in_valid && in_ready;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.end_hit) begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = sts.frame_ok ? ST_HIST_MUL : ST_LOAD;
        end
      end
      ST_HIST_MUL: begin
        cmd.hist_mul = 1'b1;
        state_nxt    = ST_HIST_ADD;
      end
      ST_HIST_ADD: begin
        cmd.hist_add = 1'b1;
        state_nxt    = ST_DRV_MUL;
      end
      ST_DRV_MUL: begin
        cmd.drv_mul = 1'b1;
        state_nxt   = ST_DRV_SUM;
      end
      ST_DRV_SUM: begin
        cmd.drv_sum = 1'b1;
        state_nxt   = ST_DRV_ADD;
      end
      ST_DRV_ADD: begin
        cmd.drv_add = 1'b1;
        state_nxt   = ST_LOAD;
      end
      ST_LOAD: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a pending result word is never overwritten
  `ECFL_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "result overwritten")
  // the window-end sample always starts the frame-end sequence
  `ECFL_ASSERT_NXT(a_end_starts_div, cmd.accept && sts.end_hit, state_r == ST_DIV_INIT, "end missed")
  // divider step count stays inside its range
  `ECFL_ASSERT_IMP(a_div_bound, state_r == ST_DIV, div_cnt_r < DIV_CNT_W'(DIV_STEPS), "div overrun")

endmodule

/* hw/rtl/ecfl_dp.sv */
// ----------------------------------------------------------------------------
// Edge centroid feedback loop: datapath
// Configuration registers, sample delay line, edge and saturation detection,
// restoring divider, leaky integrator, drive accumulator and result register.
// ----------------------------------------------------------------------------
module ecfl_dp import ecfl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ecfl_cmd_t                     cmd,
  output ecfl_sts_t                     sts,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_frame_start,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic signed [DRIVE_W-1:0]     out_drive,
  output logic                          out_frame_valid,
  output logic                          out_saturated,
  output logic [EDGE_W-1:0]             out_edge_total,
  output logic signed [CERR_W-1:0]      out_center_error,
  output logic                          out_rail_hit
);

  localparam int MHI_W  = DECAY_W + HIST_W - HIST_SPLIT + 1;
  localparam int MLO_W  = DECAY_W + HIST_SPLIT;
  localparam int HSUM_W = MHI_W + 2;
  localparam int PHI_W  = HIST_W - HIST_SPLIT + GAIN_W;
  localparam int PLO_W  = HIST_SPLIT + 1 + GAIN_W;
  localparam int PROD_W = HIST_W + GAIN_W;
  localparam int STEP_W = PROD_W - DRV_SHIFT;
  localparam int DSUM_W = STEP_W + 2;
  localparam logic signed [DSUM_W-1:0] DSUM_ONE = DSUM_W'(DRIVE_ONE);
  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  // configuration
  logic [SAMPLE_BITS-1:0]        edge_thr_r, edge_thr_nxt;
  logic signed [SAMPLE_BITS-1:0] sat_lvl_r, sat_lvl_nxt;
  logic [POS_W-1:0]              win_start_r, win_start_nxt;
  logic [POS_W-1:0]              win_end_r, win_end_nxt;
  logic [EDGE_W-1:0]             min_edges_r, min_edges_nxt;
  logic [POS_W-1:0]              ctr_off_r, ctr_off_nxt;
  logic [DECAY_W-1:0]            decay_r, decay_nxt;
  logic signed [GAIN_W-1:0]      gain_r, gain_nxt;

  // frame state
  logic signed [SAMPLE_BITS-1:0] dly_r [DLY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] dly_nxt [DLY_DEPTH];
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic                          done_r, done_nxt;
  logic [EDGE_W-1:0]             edge_r, edge_nxt;
  logic [OFFS_W-1:0]             offs_r, offs_nxt;
  logic                          sat_r, sat_nxt;

  // frame-end arithmetic
  logic [QUO_W-1:0]              quo_r, quo_nxt;
  logic [EDGE_W-1:0]             rem_r, rem_nxt;
  logic signed [MHI_W-1:0]       m_hi_r, m_hi_nxt;
  logic [MLO_W-1:0]              m_lo_r, m_lo_nxt;
  logic signed [HIST_W-1:0]      hist_r, hist_nxt;
  logic signed [PHI_W-1:0]       p_hi_r, p_hi_nxt;
  logic signed [PLO_W-1:0]       p_lo_r, p_lo_nxt;
  logic signed [STEP_W-1:0]      step_r, step_nxt;
  logic signed [DRIVE_W-1:0]     drive_r, drive_nxt;
  logic                          rail_r, rail_nxt;

  // result word
  logic signed [DRIVE_W-1:0]     o_drive_r, o_drive_nxt;
  logic                          o_valid_r, o_valid_nxt;
  logic                          o_sat_r, o_sat_nxt;
  logic [EDGE_W-1:0]             o_edges_r, o_edges_nxt;
  logic signed [CERR_W-1:0]      o_cerr_r, o_cerr_nxt;
  logic                          o_rail_r, o_rail_nxt;

  // per-sample terms
  logic [POS_W-1:0]              idx;
  logic                          done_eff;
  logic                          in_win;
  logic signed [SAMPLE_BITS:0]   rise;
  logic                          is_edge;
  logic                          sat_hit;
  logic [EDGE_W:0]               trial;
  logic                          div_ge;
  logic signed [CERR_FULL_W-1:0] cerr;
  logic [HSUM_W-1:0]             hsum;
  logic [PROD_W-1:0]             prod;
  logic signed [DSUM_W-1:0]      dsum;

  // sample index and window test; frame start renumbers from zero
  always_comb begin
    idx      = in_frame_start ? '0 : pos_r;
    done_eff = in_frame_start ? 1'b0 : done_r;
    in_win   = (idx > win_start_r) && (idx <= win_end_r);
    rise     = {in_sample[SAMPLE_BITS-1], in_sample} -
               {dly_r[0][SAMPLE_BITS-1], dly_r[0]};
    is_edge  = rise >= $signed({1'b0, edge_thr_r});
    sat_hit  = (in_sample > sat_lvl_r) &&
               (dly_r[SAT_TAP_SPACING] > sat_lvl_r) &&
               (dly_r[2*SAT_TAP_SPACING] > sat_lvl_r) &&
               (dly_r[3*SAT_TAP_SPACING] > sat_lvl_r) &&
               (dly_r[4*SAT_TAP_SPACING] > sat_lvl_r);
    sts.end_hit  = !done_eff && (idx == win_end_r);
    sts.frame_ok = (edge_r >= min_edges_r) && !sat_r;
  end

  // divider step and centre error
  always_comb begin
    trial  = {rem_r, quo_r[QUO_W-1]};
    div_ge = trial >= {1'b0, edge_r};
    if (edge_r == '0) begin
      cerr = '0;
    end else begin
      cerr = $signed({1'b0, quo_r}) -
             $signed(CERR_FULL_W'({ctr_off_r, {FRAC_BITS{1'b0}}}));
    end
  end

  // integrator sum, drive product sum and clamp input
  always_comb begin
    hsum = {{(HSUM_W-MHI_W){m_hi_r[MHI_W-1]}}, m_hi_r} +
           HSUM_W'(m_lo_r[MLO_W-1:HIST_SPLIT]) +
           {{(HSUM_W-CERR_FULL_W){cerr[CERR_FULL_W-1]}}, cerr};
    prod = {p_hi_r, {HIST_SPLIT{1'b0}}} +
           {{(PROD_W-PLO_W){p_lo_r[PLO_W-1]}}, p_lo_r};
    dsum = {{(DSUM_W-DRIVE_W){drive_r[DRIVE_W-1]}}, drive_r} +
           {{(DSUM_W-STEP_W){step_r[STEP_W-1]}}, step_r};
  end

  // configuration writes
  always_comb begin
    edge_thr_nxt  = edge_thr_r;
    sat_lvl_nxt   = sat_lvl_r;
    win_start_nxt = win_start_r;
    win_end_nxt   = win_end_r;
    min_edges_nxt = min_edges_r;
    ctr_off_nxt   = ctr_off_r;
    decay_nxt     = decay_r;
    gain_nxt      = gain_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EDGE_THRESHOLD:   edge_thr_nxt  = cfg_data[SAMPLE_BITS-1:0];
        REG_SATURATION_LEVEL: sat_lvl_nxt   = $signed(cfg_data[SAMPLE_BITS-1:0]);
        REG_WINDOW_START:     win_start_nxt = cfg_data[POS_W-1:0];
        REG_WINDOW_END:       win_end_nxt   = cfg_data[POS_W-1:0];
        REG_MIN_EDGES:        min_edges_nxt = cfg_data[EDGE_W-1:0];
        REG_CENTER_OFFSET:    ctr_off_nxt   = cfg_data[POS_W-1:0];
        REG_DECAY:            decay_nxt     = cfg_data[DECAY_W-1:0];
        REG_GAIN:             gain_nxt      = $signed(cfg_data[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // per-sample frame state
  always_comb begin
    pos_nxt  = pos_r;
    done_nxt = done_r;
    edge_nxt = edge_r;
    offs_nxt = offs_r;
    sat_nxt  = sat_r;
    for (int i = 0; i < DLY_DEPTH; i++) begin
      dly_nxt[i] = dly_r[i];
    end
    if (cmd.accept) begin
      if (in_frame_start) begin
        edge_nxt = '0;
        offs_nxt = '0;
        sat_nxt  = 1'b0;
        done_nxt = 1'b0;
      end
      if (!done_eff) begin
        if (in_win) begin
          if (is_edge) begin
            edge_nxt = edge_nxt + 1'b1;
            offs_nxt = offs_nxt + OFFS_W'(idx - win_start_r);
          end
          if (sat_hit) begin
            sat_nxt = 1'b1;
          end
        end
        if (idx == POS_W'(FRAME_LENGTH - 1)) begin
          done_nxt = 1'b1;
        end else begin
          pos_nxt = idx + 1'b1;
        end
      end
      dly_nxt[0] = in_sample;
      for (int i = 1; i < DLY_DEPTH; i++) begin
        dly_nxt[i] = dly_r[i-1];
      end
    end
  end

  // frame-end arithmetic, one command per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    m_hi_nxt = m_hi_r;
    m_lo_nxt = m_lo_r;
    hist_nxt = hist_r;
    p_hi_nxt = p_hi_r;
    p_lo_nxt = p_lo_r;
    step_nxt = step_r;
    drive_nxt = drive_r;
    rail_nxt  = rail_r;
    if (cmd.div_init) begin
      quo_nxt  = {offs_r, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      rail_nxt = 1'b0;
    end
    if (cmd.div_step) begin
      quo_nxt = {quo_r[QUO_W-2:0], div_ge};
      rem_nxt = div_ge ? EDGE_W'(trial - {1'b0, edge_r}) : trial[EDGE_W-1:0];
    end
    // history times decay, split into high and low halves
    if (cmd.hist_mul) begin
      m_hi_nxt = $signed({1'b0, decay_r}) * $signed(hist_r[HIST_W-1:HIST_SPLIT]);
      m_lo_nxt = decay_r * hist_r[HIST_SPLIT-1:0];
    end
    // add the error and saturate to the history width
    if (cmd.hist_add) begin
      if (!hsum[HSUM_W-1] && (hsum[HSUM_W-2:HIST_W-1] != '0)) begin
        hist_nxt = HIST_MAX;
      end else if (hsum[HSUM_W-1] && (hsum[HSUM_W-2:HIST_W-1] != '1)) begin
        hist_nxt = HIST_MIN;
      end else begin
        hist_nxt = $signed(hsum[HIST_W-1:0]);
      end
    end
    // history times gain, split into high and low halves
    if (cmd.drv_mul) begin
      p_hi_nxt = $signed(hist_r[HIST_W-1:HIST_SPLIT]) * gain_r;
      p_lo_nxt = $signed({1'b0, hist_r[HIST_SPLIT-1:0]}) * gain_r;
    end
    if (cmd.drv_sum) begin
      step_nxt = $signed(prod[PROD_W-1:DRV_SHIFT]);
    end
    // accumulate and clamp to plus or minus one
    if (cmd.drv_add) begin
      if (dsum > DSUM_ONE) begin
        drive_nxt = DRIVE_W'(DRIVE_ONE);
        rail_nxt  = 1'b1;
      end else if (dsum < -DSUM_ONE) begin
        drive_nxt = DRIVE_W'(-DRIVE_ONE);
        rail_nxt  = 1'b1;
      end else begin
        drive_nxt = dsum[DRIVE_W-1:0];
      end
    end
  end

  // result word
  always_comb begin
    o_drive_nxt = o_drive_r;
    o_valid_nxt = o_valid_r;
    o_sat_nxt   = o_sat_r;
    o_edges_nxt = o_edges_r;
    o_cerr_nxt  = o_cerr_r;
    o_rail_nxt  = o_rail_r;
    if (cmd.load_out) begin
      o_drive_nxt = drive_r;
      o_valid_nxt = sts.frame_ok;
      o_sat_nxt   = sat_r;
      o_edges_nxt = edge_r;
      o_cerr_nxt  = cerr[CERR_W-1:0];
      o_rail_nxt  = rail_r;
    end
  end

  // control and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_thr_r  <= SAMPLE_BITS'(410);
      sat_lvl_r   <= SAMPLE_BITS'(6554);
      win_start_r <= POS_W'(390);
      win_end_r   <= POS_W'(8191);
      min_edges_r <= EDGE_W'(20);
      ctr_off_r   <= POS_W'(3870);
      decay_r     <= DECAY_W'(45875);
      gain_r      <= GAIN_W'(-164840);
      pos_r       <= '0;
      done_r      <= 1'b0;
      edge_r      <= '0;
      offs_r      <= '0;
      sat_r       <= 1'b0;
      hist_r      <= '0;
      drive_r     <= '0;
      rail_r      <= 1'b0;
      for (int i = 0; i < DLY_DEPTH; i++) begin
        dly_r[i] <= '0;
      end
    end else begin
      edge_thr_r  <= edge_thr_nxt;
      sat_lvl_r   <= sat_lvl_nxt;
      win_start_r <= win_start_nxt;
      win_end_r   <= win_end_nxt;
      min_edges_r <= min_edges_nxt;
      ctr_off_r   <= ctr_off_nxt;
      decay_r     <= decay_nxt;
      gain_r      <= gain_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      edge_r      <= edge_nxt;
      offs_r      <= offs_nxt;
      sat_r       <= sat_nxt;
      hist_r      <= hist_nxt;
      drive_r     <= drive_nxt;
      rail_r      <= rail_nxt;
      for (int i = 0; i < DLY_DEPTH; i++) begin
        dly_r[i] <= dly_nxt[i];
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    m_hi_r    <= m_hi_nxt;
    m_lo_r    <= m_lo_nxt;
    p_hi_r    <= p_hi_nxt;
    p_lo_r    <= p_lo_nxt;
    step_r    <= step_nxt;
    o_drive_r <= o_drive_nxt;
    o_valid_r <= o_valid_nxt;
    o_sat_r   <= o_sat_nxt;
    o_edges_r <= o_edges_nxt;
    o_cerr_r  <= o_cerr_nxt;
    o_rail_r  <= o_rail_nxt;
  end

  assign out_drive        = o_drive_r;
  assign out_frame_valid  = o_valid_r;
  assign out_saturated    = o_sat_r;
  assign out_edge_total   = o_edges_r;
  assign out_center_error = o_cerr_r;
  assign out_rail_hit     = o_rail_r;

endmodule
